FILE: design/rrld_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and register codes of the refresh rate lock detector.
// No dependencies; every other design file imports this package.
package rrld_pkg;

  // Block sizing
  localparam int PERIOD_BITS  = 20;
  localparam int LOCK_SAMPLES = 8;
  localparam int MAX_DIVISOR  = 4;

  // Fixed field and register widths
  localparam int FRAC_BITS = 8;
  localparam int REG_W     = 20;
  localparam int TOL_W     = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = 3;
  localparam int CNT_W     = 4;
  localparam int FRAME_W   = 22;

  // Average filter: weight 6554/65536 with floor shift
  localparam int WEIGHT       = 6554;
  localparam int WEIGHT_SHIFT = 16;

  // Lock test scaling: native*2^24 against n*avg*2^16
  localparam int TARGET_SHIFT = 24;
  localparam int SCALE_SHIFT  = 16;

  // Derived datapath widths
  localparam int AVG_W   = PERIOD_BITS + FRAC_BITS;
  localparam int PROD_W  = AVG_W + DIV_W;
  localparam int MUL_A_W = PROD_W + 1;
  localparam int MUL_B_W = TOL_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int TGT_W   = REG_W + TARGET_SHIFT;
  localparam int SCL_W   = PROD_W + SCALE_SHIFT;
  localparam int DEV_W   = (TGT_W > SCL_W) ? TGT_W : SCL_W;
  localparam int CMP_W   = (DEV_W > MUL_P_W) ? DEV_W : MUL_P_W;
  localparam int LIM_W   = (PERIOD_BITS > REG_W) ? PERIOD_BITS : REG_W;

  // Register reset values
  localparam logic [REG_W-1:0] NATIVE_RST  = REG_W'(16639);
  localparam logic [TOL_W-1:0] TOL_RST     = TOL_W'(655);
  localparam logic [REG_W-1:0] LONGEST_RST = REG_W'(100000);

  // Register indexes of the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NATIVE  = 2'd0,
    CFG_TOL     = 2'd1,
    CFG_LONGEST = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] native;
    logic [TOL_W-1:0] tol;
    logic [REG_W-1:0] longest;
  } cfg_t;

  typedef struct packed {
    logic               locked;
    logic [DIV_W-1:0]   ticks;
    logic [FRAME_W-1:0] frame;
  } res_t;

endpackage

FILE: design/refresh_rate_lock_detector_core.sv
`timescale 1ns / 1ps
// Top level of the refresh rate lock detector: configuration registers,
// handshakes and output register. Depends on rrld_pkg and rrld_seq.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------------
//   input    | in        | in_valid_i/in_stall_o  | period_i
//   output   | out       | out_valid_o/out_stall_i| locked_o, frame_divisor_o,
//            |           |                        | frame_period_o
//   config   | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// An interval is taken in S_IDLE and checked in S_EVAL; unless it resets
// or is the first sample, S_AVG updates the average, and each divisor
// tried (up to 4) takes an S_DEV and an S_CMP step before S_DONE hands the
// result over; the shared multiplier sets the pace.
// in_stall_o stays high from the transfer of an interval until its result
// sits in the output register; that register holds one result while the
// next interval is taken. Reset restores the register defaults and clears
// the average, sample count and output valid.
module refresh_rate_lock_detector_core import rrld_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [PERIOD_BITS-1:0] period_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   locked_o,
  output logic [DIV_W-1:0]       frame_divisor_o,
  output logic [FRAME_W-1:0]     frame_period_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  cfg_t cfg_q;
  res_t out_q;
  logic out_valid_q;
  logic seq_idle;
  logic res_valid;
  res_t res;
  logic res_take;
  logic start;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.native  <= NATIVE_RST;
      cfg_q.tol     <= TOL_RST;
      cfg_q.longest <= LONGEST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NATIVE:  cfg_q.native  <= cfg_wdata_i[REG_W-1:0];
        CFG_TOL:     cfg_q.tol     <= cfg_wdata_i[TOL_W-1:0];
        CFG_LONGEST: cfg_q.longest <= cfg_wdata_i[REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !seq_idle;
  assign start      = in_valid_i && seq_idle;
  // hand a result over when the output register is empty or drains now
  assign res_take   = res_valid && (!out_valid_q || !out_stall_i);

  rrld_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .period_i    (period_i),
    .cfg_i       (cfg_q),
    .take_i      (res_take),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign locked_o        = out_q.locked;
  assign frame_divisor_o = out_q.ticks;
  assign frame_period_o  = out_q.frame;

  // A transfer in closes the input until the result is handed over
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open in the cycle after a transfer");

  // A handed-over result shows up at the output
  a_take_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_o)
    else $error("result handed over but output not valid");

  // A locked result carries a divisor in range
  a_locked_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && locked_o) |->
      (frame_divisor_o != '0) && (frame_divisor_o <= DIV_W'(MAX_DIVISOR)))
    else $error("locked result with divisor out of range");

  // An unlocked result is all zero
  a_unlocked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !locked_o) |-> (frame_divisor_o == '0) && (frame_period_o == '0))
    else $error("unlocked result with non-zero fields");

endmodule

FILE: design/rrld_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with registered product, used for the filter weight
// and for the tolerance bound in turn. Depends on rrld_pkg.
module rrld_mul import rrld_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] p_o
);

  // Register the product every cycle
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

FILE: design/rrld_seq.sv
`timescale 1ns / 1ps
// Sequencer and datapath: average update, warm-up count and divisor search,
// all through the shared multiplier. Depends on rrld_pkg and rrld_mul.
module rrld_seq import rrld_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [PERIOD_BITS-1:0] period_i,
  input  cfg_t                   cfg_i,
  input  logic                   take_i,
  output logic                   idle_o,
  output logic                   res_valid_o,
  output res_t                   res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_AVG,
    S_DEV,
    S_CMP,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [PERIOD_BITS-1:0]   p_q;
  logic [AVG_W-1:0]         avg_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [PROD_W-1:0]        prod_q;
  logic [DIV_W-1:0]         n_q;
  logic [DEV_W-1:0]         dev_q;
  res_t                     res_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [AVG_W:0]     diff;
  logic [AVG_W-1:0]          p_first;
  logic [AVG_W-1:0]          avg_new;
  logic                      invalid;
  logic [CNT_W-1:0]          cnt_d;
  logic                      warm;
  logic [DEV_W-1:0]          target;
  logic [DEV_W-1:0]          scaled;
  logic [DEV_W-1:0]          dev_d;
  logic                      fits;
  logic [FRAME_W-1:0]        frame;

  rrld_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Filter step and lock-test arithmetic
  always_comb begin
    p_first = {p_q, {FRAC_BITS{1'b0}}};
    diff    = $signed({1'b0, p_first}) - $signed({1'b0, avg_q});
    if (state_q == S_EVAL) begin
      mul_a = MUL_A_W'(diff);
      mul_b = MUL_B_W'(WEIGHT);
    end else begin
      mul_a = $signed({1'b0, prod_q});
      mul_b = $signed({1'b0, cfg_i.tol});
    end
    // floor shift of the weighted difference, wrapped to the average width
    avg_new = avg_q + mul_p[WEIGHT_SHIFT +: AVG_W];
    invalid = (p_q == '0) || (LIM_W'(p_q) > LIM_W'(cfg_i.longest));
    cnt_d   = (cnt_q < CNT_W'(LOCK_SAMPLES)) ? cnt_q + CNT_W'(1) : cnt_q;
    warm    = cnt_d < CNT_W'(LOCK_SAMPLES);
    target  = DEV_W'({cfg_i.native, {TARGET_SHIFT{1'b0}}});
    scaled  = DEV_W'({prod_q, {SCALE_SHIFT{1'b0}}});
    dev_d   = (target > scaled) ? target - scaled : scaled - target;
    fits    = CMP_W'(dev_q) <= CMP_W'($unsigned(mul_p));
    frame   = FRAME_W'(prod_q >> FRAC_BITS);
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  // Sequencer: one step of work per cycle, but S_DONE holds until the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      p_q     <= '0;
      avg_q   <= '0;
      cnt_q   <= '0;
      prod_q  <= '0;
      n_q     <= '0;
      dev_q   <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            p_q     <= period_i;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_q <= '0;
          if (invalid) begin
            // drop all history and report unlocked
            avg_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DONE;
          end else if (cnt_q == '0) begin
            // first sample loads the average
            avg_q   <= p_first;
            cnt_q   <= cnt_d;
            prod_q  <= PROD_W'(p_first);
            n_q     <= DIV_W'(1);
            state_q <= warm ? S_DONE : S_DEV;
          end else begin
            state_q <= S_AVG;
          end
        end
        S_AVG: begin
          avg_q   <= avg_new;
          cnt_q   <= cnt_d;
          prod_q  <= PROD_W'(avg_new);
          n_q     <= DIV_W'(1);
          state_q <= warm ? S_DONE : S_DEV;
        end
        S_DEV: begin
          // tolerance bound is in the multiplier this cycle
          dev_q   <= dev_d;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (fits) begin
            res_q.locked <= 1'b1;
            res_q.ticks  <= n_q;
            res_q.frame  <= frame;
            state_q      <= S_DONE;
          end else if (n_q == DIV_W'(MAX_DIVISOR)) begin
            state_q <= S_DONE;
          end else begin
            // advance to the next divisor
            prod_q  <= prod_q + PROD_W'(avg_q);
            n_q     <= n_q + DIV_W'(1);
            state_q <= S_DEV;
          end
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
